### src/apcl_pkg.sv
package apcl_pkg;

  // table geometry
  localparam int AXIS_LEN_DEF = 1024;
  localparam int ENTRY_W      = 10;

  // field widths
  localparam int VAL_W   = 32;
  localparam int PIX_W   = 16;
  localparam int WID_W   = 31;
  localparam int ST_W    = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  // one table word holds centre, width and variance
  localparam int RAM_W = 3 * VAL_W;

  // Q16.16 constants
  localparam logic [VAL_W-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [VAL_W-1:0] HALF_Q  = 32'h0000_8000;
  localparam logic [VAL_W-1:0] C_MAX   = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] C_MIN   = 32'h8000_0000;
  localparam logic [WID_W-1:0] ONE_W   = 31'h0001_0000;

  // item function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_SPACING      = 2'd1;
  localparam logic [ST_W-1:0] ST_NEG_WIDTH    = 2'd2;
  localparam logic [ST_W-1:0] ST_NEG_VARIANCE = 2'd3;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_LOWER_BOUND   = 3'd0,
    CFG_UPPER_BOUND   = 3'd1,
    CFG_HAVE_CENTRE   = 3'd2,
    CFG_HAVE_WIDTH    = 3'd3,
    CFG_HAVE_VARIANCE = 3'd4
  } cfg_reg_e;

  // absolute value already taken, clamp to the 31-bit width range
  function automatic logic [WID_W-1:0] sat_w31(logic [33:0] v);
    logic [WID_W-1:0] r;
    if (v > 34'h0_7FFF_FFFF) begin
      r = '1;
    end else begin
      r = v[WID_W-1:0];
    end
    return r;
  endfunction

  // signed clamp of a wide sum to the 32-bit centre range
  function automatic logic [VAL_W-1:0] sat_c32(logic [51:0] v);
    logic [VAL_W-1:0] r;
    if (v[51:31] != {21{v[51]}}) begin
      r = v[51] ? C_MIN : C_MAX;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/axis_pixel_coordinate_lookup_top.sv
// Pixel index to axis coordinate converter. A load item (func 0) writes one
// slot of the centre, width and variance tables, held together in one word
// of a single table memory with one write port and two registered read
// ports; slot k belongs to pixel index lower_bound + k, and loads to slots
// at or beyond AXIS_LEN are dropped. A convert item (func 1) returns one
// result: the Q16.16 centre, width and variance of the pixel, or zeros with
// a nonzero status for zero end spacing, a negative stored width or a
// negative stored variance. Without a centre table the result is the index
// minus one half, width one, variance zero. Indices outside the bounds are
// extrapolated from the end spacing with a saturating multiply-add. A load
// is written on acceptance. A convert holds the input side from acceptance
// until the next item can be taken: a step that works out the
// table geometry, two table reads (two neighbours, then the slot itself),
// one multiply stage and one stage that forms the result into the output
// register. The result register frees the input side while a result waits
// to be taken; a convert only stalls in its last stage if the previous
// result is still waiting. Tables are not cleared after reset: every slot a
// convert needs must be loaded first. Configuration writes are taken at
// any time and must only be issued while the block is idle.
module axis_pixel_coordinate_lookup_top
  import apcl_pkg::*;
#(
  parameter int AXIS_LEN = AXIS_LEN_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CIDX_W-1:0]         cfg_index_i,
  input  logic [CDATA_W-1:0]        cfg_data_i,

  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [ENTRY_W-1:0]        entry_index_i,
  input  logic signed [VAL_W-1:0]   centre_value_i,
  input  logic signed [VAL_W-1:0]   width_value_i,
  input  logic signed [VAL_W-1:0]   variance_value_i,
  input  logic signed [PIX_W-1:0]   pixel_index_i,
  input  logic                      last_pixel_i,

  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VAL_W-1:0]   centre_out_o,
  output logic [WID_W-1:0]          width_out_o,
  output logic [WID_W-1:0]          variance_out_o,
  output logic [ST_W-1:0]           status_code_o,
  output logic                      last_result_o
);

  // address width of the table memory
  localparam int AW = (AXIS_LEN > 1) ? $clog2(AXIS_LEN) : 1;
  // entry index widened to cover the address when the table is deep
  localparam int IW = (AW > ENTRY_W) ? AW : ENTRY_W;
  // geometry math: 16-bit indices plus span plus sign headroom
  localparam int GW = 18;
  localparam logic signed [GW-1:0] SPAN_MAX = GW'(AXIS_LEN - 1);
  localparam logic signed [GW-1:0] G_ONE    = 18'sd1;
  localparam logic signed [GW-1:0] G_ZERO   = 18'sd0;

  // convert sequencer
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GEO  = 6'b000010,
    S_RD1  = 6'b000100,
    S_RD2  = 6'b001000,
    S_MUL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic signed [PIX_W-1:0] lower_q, upper_q;
  logic                    have_centre_q, have_width_q, have_variance_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q         <= 16'sd1;
      upper_q         <= 16'sd1;
      have_centre_q   <= 1'b0;
      have_width_q    <= 1'b0;
      have_variance_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LOWER_BOUND:   lower_q         <= $signed(cfg_data_i);
        CFG_UPPER_BOUND:   upper_q         <= $signed(cfg_data_i);
        CFG_HAVE_CENTRE:   have_centre_q   <= cfg_data_i[0];
        CFG_HAVE_WIDTH:    have_width_q    <= cfg_data_i[0];
        CFG_HAVE_VARIANCE: have_variance_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input handshake
  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // loads write straight into the table on acceptance
  logic             ram_we;
  logic [IW-1:0]    ent_ext;
  logic [AW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;

  assign ent_ext   = IW'(entry_index_i);
  assign ram_waddr = ent_ext[AW-1:0];
  assign ram_we    = in_acc && (func_i == FUNC_LOAD) && (32'(entry_index_i) < AXIS_LEN);
  assign ram_wdata = {centre_value_i, width_value_i, variance_value_i};

  // item held while a convert runs
  logic signed [PIX_W-1:0] ipix_q;
  logic                    last_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FUNC_CONVERT) begin
      ipix_q <= pixel_index_i;
      last_q <= last_pixel_i;
    end
  end

  // geometry: clamped span, class of the index, read addresses
  logic signed [GW-1:0] lb_g, ub_g, ipix_g, span_raw_g, span_g, off_g, delta_g;
  logic signed [GW-1:0] pa_g, pb_g, pm_g;
  logic                 below_g, above_g;

  always_comb begin
    lb_g       = $signed({{(GW-PIX_W){lower_q[PIX_W-1]}}, lower_q});
    ipix_g     = $signed({{(GW-PIX_W){ipix_q[PIX_W-1]}}, ipix_q});
    span_raw_g = $signed({{(GW-PIX_W){upper_q[PIX_W-1]}}, upper_q}) - lb_g;
    if (span_raw_g < G_ZERO) begin
      span_g = G_ZERO;
    end else if (span_raw_g > SPAN_MAX) begin
      span_g = SPAN_MAX;
    end else begin
      span_g = span_raw_g;
    end
    ub_g    = lb_g + span_g;
    off_g   = ipix_g - lb_g;
    below_g = ipix_g < lb_g;
    above_g = ipix_g > ub_g;
    // offset from the nearest edge: signed so below and above share the multiply-add
    delta_g = above_g ? (ipix_g - ub_g) : off_g;
    if (below_g) begin
      pa_g = G_ZERO;
      pb_g = G_ONE;
      pm_g = G_ZERO;
    end else if (above_g) begin
      pa_g = span_g - G_ONE;
      pb_g = span_g;
      pm_g = span_g;
    end else begin
      pa_g = off_g - G_ONE;
      pb_g = off_g + G_ONE;
      pm_g = off_g;
    end
  end

  logic                 outside_q, span_gt0_q, off_gt0_q, off_lt_span_q;
  logic signed [GW-1:0] delta_q;
  logic [AW-1:0]        addr_a_q, addr_b_q, addr_m_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_GEO) begin
      outside_q     <= below_g || above_g;
      span_gt0_q    <= (span_g != G_ZERO);
      off_gt0_q     <= (off_g != G_ZERO);
      off_lt_span_q <= (off_g < span_g);
      delta_q       <= delta_g;
      addr_a_q      <= pa_g[AW-1:0];
      addr_b_q      <= pb_g[AW-1:0];
      addr_m_q      <= pm_g[AW-1:0];
    end
  end

  // table memory: neighbour pair first, then the slot itself on port a
  logic             ram_re_a, ram_re_b;
  logic [AW-1:0]    ram_raddr_a;
  logic [RAM_W-1:0] rdata_a, rdata_b;

  assign ram_re_a    = (state_q == S_RD1) || (state_q == S_RD2);
  assign ram_re_b    = (state_q == S_RD1);
  assign ram_raddr_a = (state_q == S_RD1) ? addr_a_q : addr_m_q;

  apcl_ram #(
    .WIDTH (RAM_W),
    .DEPTH (AXIS_LEN)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (ram_re_a),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (ram_re_b),
    .raddr_b_i (addr_b_q),
    .rdata_b_o (rdata_b)
  );

  // word fields; port b keeps the upper neighbour until the next convert
  logic signed [VAL_W-1:0] rd_c, rd_w, rd_v, cb;

  assign rd_c = $signed(rdata_a[3*VAL_W-1:2*VAL_W]);
  assign rd_w = $signed(rdata_a[2*VAL_W-1:VAL_W]);
  assign rd_v = $signed(rdata_a[VAL_W-1:0]);
  assign cb   = $signed(rdata_b[3*VAL_W-1:2*VAL_W]);

  // end spacing, one when the table has a single entry
  logic signed [VAL_W-1:0] ca_q;
  logic signed [VAL_W:0]   space_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD2) begin
      ca_q    <= rd_c;
      space_q <= span_gt0_q ? ($signed({cb[VAL_W-1], cb}) - $signed({rd_c[VAL_W-1], rd_c}))
                            : $signed({1'b0, ONE_Q});
    end
  end

  // derived width from the centre spacing, and the extrapolation product
  logic signed [VAL_W-1:0] wx, wy;
  logic signed [VAL_W:0]   dsel;
  logic [VAL_W:0]          mag;
  logic [33:0]             rnd;
  logic                    two_nb;
  logic [WID_W-1:0]        wid_d, wid_q;
  logic signed [50:0]      prod_d, prod_q;

  always_comb begin
    two_nb = off_gt0_q && off_lt_span_q;
    if (two_nb) begin
      wx = cb;
      wy = ca_q;
    end else if (off_gt0_q) begin
      wx = rd_c;
      wy = ca_q;
    end else begin
      wx = cb;
      wy = rd_c;
    end
    dsel = outside_q ? space_q
                     : ($signed({wx[VAL_W-1], wx}) - $signed({wy[VAL_W-1], wy}));
    mag  = dsel[VAL_W] ? $unsigned(-dsel) : $unsigned(dsel);
    // two neighbours: half the distance, ties away from zero
    rnd  = (two_nb && !outside_q) ? (({1'b0, mag} + 34'd1) >> 1) : {1'b0, mag};
    if (!outside_q && !off_gt0_q && !off_lt_span_q) begin
      wid_d = ONE_W;
    end else begin
      wid_d = sat_w31(rnd);
    end
    prod_d = space_q * delta_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      wid_q  <= wid_d;
      prod_q <= prod_d;
    end
  end

  // result forming
  logic [VAL_W-1:0] dflt_c, sum_c;
  logic [51:0]      sum_w;
  logic [VAL_W-1:0] res_c;
  logic [WID_W-1:0] res_w, res_v;
  logic [ST_W-1:0]  res_st;

  always_comb begin
    dflt_c = (ipix_q == 16'sh8000) ? C_MIN : ({ipix_q, 16'h0000} - HALF_Q);
    sum_w  = $signed({{20{rd_c[VAL_W-1]}}, rd_c}) + $signed({prod_q[50], prod_q});
    sum_c  = sat_c32(sum_w);
    res_st = ST_OK;
    res_c  = '0;
    res_w  = '0;
    res_v  = '0;
    if (!have_centre_q) begin
      res_c = dflt_c;
      res_w = ONE_W;
    end else if (outside_q) begin
      if (space_q == '0) begin
        res_st = ST_SPACING;
      end else begin
        res_c = sum_c;
        if (have_width_q) begin
          if (rd_w[VAL_W-1]) begin
            res_st = ST_NEG_WIDTH;
          end else begin
            res_w = rd_w[WID_W-1:0];
          end
        end else begin
          res_w = wid_q;
        end
      end
    end else begin
      res_c = rd_c;
      if (have_width_q) begin
        if (rd_w[VAL_W-1]) begin
          res_st = ST_NEG_WIDTH;
        end else begin
          res_w = rd_w[WID_W-1:0];
        end
      end else begin
        res_w = wid_q;
      end
      if (res_st == ST_OK && have_variance_q) begin
        if (rd_v[VAL_W-1]) begin
          res_st = ST_NEG_VARIANCE;
        end else begin
          res_v = rd_v[WID_W-1:0];
        end
      end
    end
    if (res_st != ST_OK) begin
      res_c = '0;
      res_w = '0;
      res_v = '0;
    end
  end

  // last stage waits only if the previous result has not been taken
  logic fin_go;
  assign fin_go = (state_q == S_FIN) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && func_i == FUNC_CONVERT) begin
          state_d = S_GEO;
        end
      end
      S_GEO:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_MUL;
      S_MUL:  state_d = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic out_valid_q, out_valid_d;

  assign out_valid_d = fin_go ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  logic [VAL_W-1:0] centre_q;
  logic [WID_W-1:0] width_q, variance_q;
  logic [ST_W-1:0]  status_q;
  logic             last_res_q;

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      centre_q   <= res_c;
      width_q    <= res_w;
      variance_q <= res_v;
      status_q   <= res_st;
      last_res_q <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign centre_out_o   = $signed(centre_q);
  assign width_out_o    = width_q;
  assign variance_out_o = variance_q;
  assign status_code_o  = status_q;
  assign last_result_o  = last_res_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_code_o != ST_OK) |->
      (centre_out_o == '0 && width_out_o == '0 && variance_out_o == '0))
    else $error("error result carries nonzero values");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !(ram_re_a || ram_re_b))
    else $error("table write overlaps a convert read");

  a_conv_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FUNC_CONVERT) |=> (state_q == S_GEO))
    else $error("convert item did not start the sequence");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o)
    else $error("finished convert produced no result");

  a_default_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && !have_centre_q) |=> (status_code_o == ST_OK && width_out_o == ONE_W))
    else $error("default coordinates gave a bad result");
`endif

endmodule

### src/apcl_ram.sv
module apcl_ram
  import apcl_pkg::*;
#(
  parameter int WIDTH = RAM_W,
  parameter int DEPTH = AXIS_LEN_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### verif/axis_pixel_coordinate_lookup_top_test.sv
module axis_pixel_coordinate_lookup_top_test;
  import apcl_pkg::*;

  // run length and pacing
  localparam int NUM_PHASES       = 24;
  localparam int ITEMS_PER_PHASE  = 11;
  localparam int DRAIN_CYCLES     = 12;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int STALL_LIMIT      = 2000;
  localparam int PRESSURE_PHASE   = 6;
  localparam int PAUSE_PHASE      = 10;

  // saturation limits of the centre and width paths
  localparam longint CEN_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint CEN_MIN = -64'sh0000_0000_8000_0000;
  localparam longint WID_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ONE_L   = 64'sh0000_0000_0001_0000;
  localparam longint HALF_L  = 64'sh0000_0000_0000_8000;

  // one input item, all fields driven even when the function ignores them
  typedef struct {
    logic                    func;
    logic [ENTRY_W-1:0]      slot;
    logic signed [VAL_W-1:0] cen;
    logic signed [VAL_W-1:0] wid;
    logic signed [VAL_W-1:0] vrc;
    logic signed [PIX_W-1:0] pix;
    logic                    last;
  } pixel_item_t;

  // one converted coordinate as it leaves the block
  typedef struct packed {
    logic signed [VAL_W-1:0] centre;
    logic [WID_W-1:0]        width;
    logic [WID_W-1:0]        variance;
    logic [ST_W-1:0]         status;
    logic                    last;
  } coord_t;

  // directed rows are either a register write or an item
  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    cfg_reg_e     reg_sel;
    logic [15:0]  reg_data;
    pixel_item_t  item;
    bit           typed;
    coord_t       want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CIDX_W-1:0]       cfg_index_i = '0;
  logic [CDATA_W-1:0]      cfg_data_i = '0;

  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    func_i = 1'b0;
  logic [ENTRY_W-1:0]      entry_index_i = '0;
  logic signed [VAL_W-1:0] centre_value_i = '0;
  logic signed [VAL_W-1:0] width_value_i = '0;
  logic signed [VAL_W-1:0] variance_value_i = '0;
  logic signed [PIX_W-1:0] pixel_index_i = '0;
  logic                    last_pixel_i = 1'b0;

  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] centre_out_o;
  logic [WID_W-1:0]        width_out_o;
  logic [WID_W-1:0]        variance_out_o;
  logic [ST_W-1:0]         status_code_o;
  logic                    last_result_o;

  // shadow of the block's tables and registers
  int                      centre_mem   [AXIS_LEN_DEF];
  int                      width_mem    [AXIS_LEN_DEF];
  int                      variance_mem [AXIS_LEN_DEF];
  logic signed [15:0]      cfg_lower = 16'sd1;
  logic signed [15:0]      cfg_upper = 16'sd1;
  bit                      cfg_have_centre = 1'b0;
  bit                      cfg_have_width = 1'b0;
  bit                      cfg_have_variance = 1'b0;

  coord_t                  pending_coords [$];
  plan_row_t               directed_plan [$];
  int                      errors = 0;
  int                      idle_cycles = 0;
  int                      burst_left = 0;
  bit                      hold_off_req = 1'b0;

  axis_pixel_coordinate_lookup_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .entry_index_i    (entry_index_i),
    .centre_value_i   (centre_value_i),
    .width_value_i    (width_value_i),
    .variance_value_i (variance_value_i),
    .pixel_index_i    (pixel_index_i),
    .last_pixel_i     (last_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .centre_out_o     (centre_out_o),
    .width_out_o      (width_out_o),
    .variance_out_o   (variance_out_o),
    .status_code_o    (status_code_o),
    .last_result_o    (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // coordinate predictor
  // ---------------------------------------------------------------------------

  // number of slots past slot 0, reversed bounds give zero, long spans clip
  function automatic int table_span();
    int s;
    s = int'(cfg_upper) - int'(cfg_lower);
    if (s < 0) s = 0;
    if (s > AXIS_LEN_DEF - 1) s = AXIS_LEN_DEF - 1;
    return s;
  endfunction

  function automatic longint clamp_centre(longint v);
    if (v > CEN_MAX) return CEN_MAX;
    if (v < CEN_MIN) return CEN_MIN;
    return v;
  endfunction

  function automatic longint abs_width(longint v);
    if (v < 0) v = -v;
    return (v > WID_MAX) ? WID_MAX : v;
  endfunction

  // loads update the shadow tables and give nothing; converts give one coordinate
  function automatic bit predict_coords(input pixel_item_t it, output coord_t r);
    longint lb, ub, pix, space, cen, wid, vrc, d, off;
    int span, tail_slot;
    logic [ST_W-1:0] st;
    r = '0;
    if (it.func == FUNC_LOAD) begin
      centre_mem[it.slot]   = it.cen;
      width_mem[it.slot]    = it.wid;
      variance_mem[it.slot] = it.vrc;
      return 1'b0;
    end
    span = table_span();
    lb = cfg_lower;
    ub = lb + span;
    pix = it.pix;
    space = ONE_L;
    cen = 0;
    wid = 0;
    vrc = 0;
    st = ST_OK;
    if (!cfg_have_centre) begin
      // default grid: pixel centres sit half a pixel below the index
      cen = clamp_centre(pix * ONE_L - HALF_L);
      wid = ONE_L;
    end else if (pix < lb || pix > ub) begin
      // outside the table: extend the end spacing linearly
      tail_slot = (pix < lb) ? 0 : span;
      if (span > 0) begin
        if (pix < lb) space = longint'(centre_mem[1]) - longint'(centre_mem[0]);
        else space = longint'(centre_mem[span]) - longint'(centre_mem[span - 1]);
        if (space == 0) st = ST_SPACING;
      end
      if (st == ST_OK) begin
        if (pix < lb) cen = clamp_centre(longint'(centre_mem[0]) - space * (lb - pix));
        else cen = clamp_centre(longint'(centre_mem[span]) + space * (pix - ub));
        if (cfg_have_width) begin
          wid = width_mem[tail_slot];
          if (wid < 0) st = ST_NEG_WIDTH;
        end else begin
          wid = abs_width(space);
        end
      end
    end else begin
      off = pix - lb;
      cen = centre_mem[off];
      if (cfg_have_width) begin
        wid = width_mem[off];
        if (wid < 0) st = ST_NEG_WIDTH;
      end else if (off > 0 && off < span) begin
        // half the neighbour distance, ties rounded away from zero
        d = longint'(centre_mem[off + 1]) - longint'(centre_mem[off - 1]);
        if (d < 0) d = -d;
        wid = abs_width((d + 1) >>> 1);
      end else if (off > 0) begin
        wid = abs_width(longint'(centre_mem[off]) - longint'(centre_mem[off - 1]));
      end else if (off < span) begin
        wid = abs_width(longint'(centre_mem[off + 1]) - longint'(centre_mem[off]));
      end else begin
        wid = ONE_L;
      end
      if (st == ST_OK && cfg_have_variance) begin
        vrc = variance_mem[off];
        if (vrc < 0) st = ST_NEG_VARIANCE;
      end
    end
    // any error status zeroes the value fields
    if (st != ST_OK) begin
      cen = 0;
      wid = 0;
      vrc = 0;
    end
    r.centre   = cen[VAL_W-1:0];
    r.width    = wid[WID_W-1:0];
    r.variance = vrc[WID_W-1:0];
    r.status   = st;
    r.last     = it.last;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // item generation
  // ---------------------------------------------------------------------------

  function automatic pixel_item_t random_noise();
    pixel_item_t it;
    it.func = 1'($urandom_range(0, 1));
    it.slot = ENTRY_W'($urandom_range(0, AXIS_LEN_DEF - 1));
    it.cen  = $urandom;
    it.wid  = $urandom;
    it.vrc  = $urandom;
    it.pix  = PIX_W'($urandom_range(0, 65535));
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // widths and variances: mostly small positive, some negative, some anything
  function automatic logic signed [VAL_W-1:0] stored_magnitude();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return $urandom | 32'h8000_0000;
    if (pick == 2) return $urandom;
    return $urandom_range(0, 32'h3FFFF);
  endfunction

  // loads cluster on the live part of the table; a few copy a neighbour
  // centre at either end so that zero end spacing shows up
  function automatic pixel_item_t rand_load(int span);
    pixel_item_t it;
    int pick;
    it = random_noise();
    it.func = FUNC_LOAD;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      it.slot = ENTRY_W'((pick == 0 || span == 0) ? 1 : span);
      it.cen = centre_mem[it.slot - 1];
    end else begin
      if (pick < 16) begin
        it.slot = ENTRY_W'($urandom_range(0, (span < AXIS_LEN_DEF - 2) ? span + 1 : 1023));
      end else begin
        it.slot = ENTRY_W'($urandom_range(0, AXIS_LEN_DEF - 1));
      end
      if (pick > 3) it.cen = int'(it.slot) * 65536 + int'($urandom_range(0, 32'h1FFFF)) - 65536;
    end
    it.wid = stored_magnitude();
    it.vrc = stored_magnitude();
    return it;
  endfunction

  // converts land mostly in and just around the bounds
  function automatic pixel_item_t rand_convert(int span);
    pixel_item_t it;
    int pick, p;
    it = random_noise();
    it.func = FUNC_CONVERT;
    pick = $urandom_range(0, 19);
    if (pick == 2) begin
      it.pix = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end else if (pick > 2) begin
      p = int'(cfg_lower) + int'($urandom_range(0, span + 6)) - 3;
      it.pix = p[PIX_W-1:0];
    end
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan builders
  // ---------------------------------------------------------------------------

  function automatic void add_reg(cfg_reg_e sel, logic [15:0] data);
    plan_row_t row;
    row = '{kind: ROW_REG, reg_sel: sel, reg_data: data, item: random_noise(),
            typed: 1'b0, want: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void add_load(logic [ENTRY_W-1:0] slot, logic signed [VAL_W-1:0] c,
                                   logic signed [VAL_W-1:0] w, logic signed [VAL_W-1:0] v);
    plan_row_t row;
    row = '{kind: ROW_ITEM, reg_sel: CFG_LOWER_BOUND, reg_data: '0, item: random_noise(),
            typed: 1'b0, want: '0};
    row.item.func = FUNC_LOAD;
    row.item.slot = slot;
    row.item.cen = c;
    row.item.wid = w;
    row.item.vrc = v;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_conv(logic signed [PIX_W-1:0] pix, logic last);
    plan_row_t row;
    row = '{kind: ROW_ITEM, reg_sel: CFG_LOWER_BOUND, reg_data: '0, item: random_noise(),
            typed: 1'b0, want: '0};
    row.item.func = FUNC_CONVERT;
    row.item.pix = pix;
    row.item.last = last;
    directed_plan.push_back(row);
  endfunction

  // convert whose result is written out by hand
  function automatic void add_conv_known(logic signed [PIX_W-1:0] pix, logic last,
                                         logic [VAL_W-1:0] c, logic [WID_W-1:0] w,
                                         logic [WID_W-1:0] v, logic [ST_W-1:0] st);
    add_conv(pix, last);
    directed_plan[$].typed = 1'b1;
    directed_plan[$].want = '{centre: c, width: w, variance: v, status: st, last: last};
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // offer one item in the current burst, predict it once it is taken
  task automatic offer(pixel_item_t it, bit typed, coord_t want);
    coord_t r;
    int gap;
    in_valid_i       <= 1'b1;
    func_i           <= it.func;
    entry_index_i    <= it.slot;
    centre_value_i   <= it.cen;
    width_value_i    <= it.wid;
    variance_value_i <= it.vrc;
    pixel_index_i    <= it.pix;
    last_pixel_i     <= it.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_coords(it, r)) begin
      if (typed) r = want;
      pending_coords.push_back(r);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // end of burst: some bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // stop offering and wait until every pending coordinate is out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_coords.size() != 0) @(posedge clk_i);
    // loads give no result and may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e sel, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (sel)
      CFG_LOWER_BOUND:   cfg_lower = data;
      CFG_UPPER_BOUND:   cfg_upper = data;
      CFG_HAVE_CENTRE:   cfg_have_centre = data[0];
      CFG_HAVE_WIDTH:    cfg_have_width = data[0];
      CFG_HAVE_VARIANCE: cfg_have_variance = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // flag write with random upper bits, only bit 0 counts
  function automatic logic [15:0] flag_word(bit f);
    return (16'($urandom) & 16'hFFFE) | {15'd0, f};
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  initial begin : result_side
    int seg_len, mode, n;
    bit rdy;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        // long hold-off so the block backs up into its input
        out_ready_i <= 1'b0;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg_len = $urandom_range(8, 60);
        // a hold-off request cuts the current segment short
        for (n = 0; n < seg_len && !hold_off_req; n++) begin
          case (mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) != 0);
            default: rdy = ((n % 7) < 2);
          endcase
          out_ready_i <= rdy;
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic void check_field(string label, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    coord_t want;
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_coords.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual centre %h status %0d",
                 $time, centre_out_o, status_code_o);
        errors++;
      end else begin
        want = pending_coords.pop_front();
        check_field("centre", centre_out_o, want.centre);
        check_field("width", 32'(width_out_o), 32'(want.width));
        check_field("variance", 32'(variance_out_o), 32'(want.variance));
        check_field("status", 32'(status_code_o), 32'(want.status));
        check_field("last", 32'(last_result_o), 32'(want.last));
      end
    end
  end

  // nothing moving for too long means the block is hung
  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[axis_pixel_coordinate_lookup_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int ph, k, span, lb_i, ub_i, pick;
    logic [15:0] lb_w, ub_w;
    bit hc, hw, hv;
    pixel_item_t it;

    // reset state of the registers: lower 1, upper 1, no tables
    add_conv_known(16'sd0, 1'b0, 32'hFFFF_8000, ONE_W, '0, ST_OK);
    add_conv_known(-16'sd32768, 1'b1, C_MIN, ONE_W, '0, ST_OK);
    add_conv_known(16'sd32767, 1'b0, 32'h7FFE_8000, ONE_W, '0, ST_OK);
    add_conv_known(16'sd1, 1'b1, 32'h0000_8000, ONE_W, '0, ST_OK);

    // four slot table from pixel 0 to 3
    add_reg(CFG_LOWER_BOUND, 16'd0);
    add_reg(CFG_UPPER_BOUND, 16'd3);
    add_reg(CFG_HAVE_CENTRE, 16'd1);
    add_reg(CFG_HAVE_WIDTH, 16'd0);
    add_reg(CFG_HAVE_VARIANCE, 16'd0);
    add_load(10'd0, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
    add_load(10'd1, 32'h0003_0000, 32'h0001_0000, 32'h0000_2000);
    add_load(10'd2, 32'h0004_0001, 32'h0001_0000, 32'h0000_2000);
    add_load(10'd3, 32'h0008_0000, 32'h0001_0000, 32'h0000_2000);
    add_conv(16'sd0, 1'b0);
    // odd neighbour distance: half rounds up
    add_conv(16'sd1, 1'b0);
    add_conv(-16'sd1, 1'b0);
    // far extrapolation saturates both ways
    add_conv_known(-16'sd32768, 1'b0, C_MIN, 31'h0002_0000, '0, ST_OK);
    add_conv_known(16'sd32767, 1'b1, C_MAX, 31'h0003_FFFF, '0, ST_OK);

    // zero spacing at the low end
    add_load(10'd1, 32'h0001_0000, 32'h0001_0000, 32'h0000_2000);
    add_conv_known(-16'sd2, 1'b0, '0, '0, '0, ST_SPACING);

    // stored negative width
    add_reg(CFG_HAVE_WIDTH, 16'd1);
    add_load(10'd2, 32'h0004_0001, 32'hFFFF_0000, 32'h0000_0100);
    add_conv_known(16'sd2, 1'b0, '0, '0, '0, ST_NEG_WIDTH);

    // stored negative variance
    add_reg(CFG_HAVE_VARIANCE, 16'd1);
    add_load(10'd3, 32'h0008_0000, 32'h0002_0000, 32'h8000_0000);
    add_conv_known(16'sd3, 1'b1, '0, '0, '0, ST_NEG_VARIANCE);

    // reversed bounds collapse to one slot
    add_reg(CFG_LOWER_BOUND, 16'd5);
    add_reg(CFG_UPPER_BOUND, 16'hFFFB);
    add_conv(16'sd10, 1'b0);

    // span wider than the table clips to the last slot
    add_reg(CFG_LOWER_BOUND, 16'h8000);
    add_reg(CFG_UPPER_BOUND, 16'h7FFF);
    add_conv(16'sd32767, 1'b0);
    add_conv(-16'sd32768, 1'b0);

    // width and variance flags do nothing without the centre table
    add_reg(CFG_HAVE_CENTRE, 16'd0);
    add_conv_known(16'sd100, 1'b1, 32'h0063_8000, ONE_W, '0, ST_OK);

    // full scale centres: derived width clamps
    add_reg(CFG_LOWER_BOUND, 16'd0);
    add_reg(CFG_UPPER_BOUND, 16'd1);
    add_reg(CFG_HAVE_CENTRE, 16'd1);
    add_reg(CFG_HAVE_WIDTH, 16'd0);
    add_reg(CFG_HAVE_VARIANCE, 16'd0);
    add_load(10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_load(10'd1, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    add_conv_known(16'sd0, 1'b0, C_MIN, 31'h7FFF_FFFF, '0, ST_OK);
    add_conv_known(16'sd1, 1'b1, C_MAX, 31'h7FFF_FFFF, '0, ST_OK);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the tables come up undefined, so every slot is loaded before any
    // convert that uses them
    for (k = 0; k < AXIS_LEN_DEF; k++) begin
      it = rand_load(0);
      it.slot = ENTRY_W'(k);
      offer(it, 1'b0, '0);
    end

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG) begin
        settle();
        write_reg(directed_plan[i].reg_sel, directed_plan[i].reg_data);
      end else begin
        offer(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // random phases, each with its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      hc = 1'b1;
      hw = 1'($urandom_range(0, 1));
      hv = 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          lb_w = 16'h8000;
          ub_w = 16'h7FFF;
        end
        1: begin
          lb_w = 16'h7FFF;
          ub_w = 16'h7FFF;
        end
        2: begin
          lb_w = 16'h8000;
          ub_w = 16'h83FF;
        end
        3: begin
          lb_w = 16'd100;
          ub_w = 16'd50;
        end
        4: begin
          lb_w = 16'($urandom);
          ub_w = lb_w + 16'd3;
          hc = 1'b0;
          hw = 1'b1;
          hv = 1'b1;
        end
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 10) lb_i = int'($urandom_range(0, 64)) - 32;
          else lb_i = int'($urandom_range(0, 65535)) - 32768;
          pick = $urandom_range(0, 19);
          if (pick < 14) span = $urandom_range(0, 8);
          else if (pick < 17) span = $urandom_range(9, AXIS_LEN_DEF - 1);
          else if (pick < 19) span = -int'($urandom_range(1, 100));
          else span = $urandom_range(AXIS_LEN_DEF, 5000);
          ub_i = lb_i + span;
          lb_w = lb_i[15:0];
          ub_w = ub_i[15:0];
          hc = ($urandom_range(0, 9) != 0);
        end
      endcase
      write_reg(CFG_LOWER_BOUND, lb_w);
      write_reg(CFG_UPPER_BOUND, ub_w);
      write_reg(CFG_HAVE_CENTRE, flag_word(hc));
      write_reg(CFG_HAVE_WIDTH, flag_word(hw));
      write_reg(CFG_HAVE_VARIANCE, flag_word(hv));
      span = table_span();

      // result side backs off while items keep coming
      if (ph == PRESSURE_PHASE) hold_off_req = 1'b1;

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender pauses mid-phase until the block has drained
        if (ph == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) settle();
        if ($urandom_range(0, 9) < 3) it = rand_load(span);
        else it = rand_convert(span);
        offer(it, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("[axis_pixel_coordinate_lookup_top] OK");
    end else begin
      $display("[axis_pixel_coordinate_lookup_top] ERROR");
    end
    $finish;
  end

endmodule
